// ----- sv/scp_pkg.sv -----
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the serial command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int MAX_ARG_CHARS = 15;
    localparam int CNT_W         = $clog2(MAX_ARG_CHARS + 1);

    localparam logic [7:0] TERM_RESET  = 8'd39;
    localparam logic [7:0] DELIM_RESET = 8'd32;

    // configuration register indexes
    localparam logic CFG_TERMINATOR = 1'b0;
    localparam logic CFG_DELIMITER  = 1'b1;

    // character codes used by the converter
    localparam logic [7:0] CHR_PLUS  = 8'd43;
    localparam logic [7:0] CHR_MINUS = 8'd45;
    localparam logic [7:0] CHR_ZERO  = 8'd48;
    localparam logic [7:0] CHR_NINE  = 8'd57;
    localparam logic [7:0] CHR_SPACE = 8'd32;
    localparam logic [7:0] CHR_TAB   = 8'd9;
    localparam logic [7:0] CHR_CR    = 8'd13;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        POS_CMD  = 2'd0,
        POS_ARG1 = 2'd1,
        POS_ARG2 = 2'd2
    } pos_t;

    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        phase_t      phase;
    } arg_state_t;

    typedef struct packed {
        logic [7:0]         command_letter;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic [1:0]         fields_seen;
        logic               too_long;
    } result_t;

    typedef struct packed {
        logic [7:0] terminator;
        logic [7:0] delimiter;
    } cfg_t;

endpackage

// ----- sv/scp_if.sv -----
// ----------------------------------------------------------------------------
// scp interfaces
// Byte input channel and parsed command output channel.
// ----------------------------------------------------------------------------
interface scp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         command_letter;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [1:0]         fields_seen;
    logic               too_long;

    modport source (
        output valid, output command_letter, output first_value,
        output second_value, output fields_seen, output too_long,
        input ready
    );
    modport sink (
        input valid, input command_letter, input first_value,
        input second_value, input fields_seen, input too_long,
        output ready
    );
endinterface

// ----- sv/scp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// scp_cfg_regs
// Terminator and delimiter character registers.
// ----------------------------------------------------------------------------
module scp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_wdata,
    output scp_pkg::cfg_t cfg
);
    import scp_pkg::*;

    logic [7:0] term_reg;
    logic [7:0] delim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg  <= TERM_RESET;
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TERMINATOR: term_reg  <= cfg_wdata;
                CFG_DELIMITER:  delim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.terminator = term_reg;
    assign cfg.delimiter  = delim_reg;

endmodule

// ----- sv/scp_arg_conv.sv -----
// ----------------------------------------------------------------------------
// scp_arg_conv
// One step of the atoi style argument converter: whitespace, sign, digits.
// ----------------------------------------------------------------------------
module scp_arg_conv (
    input  logic                [7:0] char_in,
    input  scp_pkg::arg_state_t       cur,
    output scp_pkg::arg_state_t       nxt
);
    import scp_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic        is_sign;
    logic [35:0] acc;
    logic [35:0] limit;
    logic [31:0] acc_sat;

    assign is_digit = (char_in >= CHR_ZERO) && (char_in <= CHR_NINE);
    assign is_space = (char_in == CHR_SPACE) || ((char_in >= CHR_TAB) && (char_in <= CHR_CR));
    assign is_sign  = (char_in == CHR_PLUS) || (char_in == CHR_MINUS);

    // mag * 10 + digit, clamped to the signed range
    assign acc   = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0}
                 + {32'd0, char_in[3:0] - CHR_ZERO[3:0]};
    assign limit = {4'd0, (cur.neg ? NEG_LIMIT : POS_LIMIT)};
    assign acc_sat = (acc > limit) ? limit[31:0] : acc[31:0];

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_LEAD:
            begin
                if (is_space)
                begin
                    nxt = cur;
                end
                else if (is_sign)
                begin
                    nxt.neg   = (char_in == CHR_MINUS);
                    nxt.phase = PH_DIGITS;
                end
                else if (!is_digit)
                begin
                    nxt.phase = PH_DONE;
                end
                else
                begin
                    nxt.phase = PH_DIGITS;
                    nxt.mag   = acc_sat;
                end
            end
            PH_DIGITS:
            begin
                if (!is_digit)
                    nxt.phase = PH_DONE;
                else
                    nxt.mag = acc_sat;
            end
            default: nxt = cur;
        endcase
    end

endmodule

// ----- sv/scp_parser.sv -----
// ----------------------------------------------------------------------------
// scp_parser
// Parse state: field position, command letter, both arguments, length check.
// ----------------------------------------------------------------------------
module scp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  scp_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic [7:0]        char_in,
    output logic              is_term,
    output scp_pkg::result_t  result
);
    import scp_pkg::*;

    pos_t             pos_reg,   pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       letter_reg, letter_next;
    arg_state_t       arg1_reg,  arg1_next;
    arg_state_t       arg2_reg,  arg2_next;
    logic             ovf_reg,   ovf_next;
    arg_state_t       arg1_conv;
    arg_state_t       arg2_conv;
    logic             is_delim;

    scp_arg_conv u_conv1 (.char_in(char_in), .cur(arg1_reg), .nxt(arg1_conv));
    scp_arg_conv u_conv2 (.char_in(char_in), .cur(arg2_reg), .nxt(arg2_conv));

    // terminator test wins over delimiter when both match
    assign is_term  = (char_in == cfg.terminator);
    assign is_delim = (char_in == cfg.delimiter);

    assign result.command_letter = letter_reg;
    assign result.first_value    = arg1_reg.neg ? -arg1_reg.mag : arg1_reg.mag;
    assign result.second_value   = arg2_reg.neg ? -arg2_reg.mag : arg2_reg.mag;
    assign result.fields_seen    = pos_reg;
    assign result.too_long       = ovf_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        count_next  = count_reg;
        letter_next = letter_reg;
        arg1_next   = arg1_reg;
        arg2_next   = arg2_reg;
        ovf_next    = ovf_reg;
        if (is_term)
        begin
            pos_next    = POS_CMD;
            count_next  = '0;
            letter_next = '0;
            arg1_next   = '{mag: '0, neg: 1'b0, phase: PH_LEAD};
            arg2_next   = '{mag: '0, neg: 1'b0, phase: PH_LEAD};
            ovf_next    = 1'b0;
        end
        else if (is_delim)
        begin
            if (pos_reg == POS_CMD)
            begin
                pos_next = POS_ARG1;
            end
            else if (pos_reg == POS_ARG1)
            begin
                pos_next   = POS_ARG2;
                count_next = '0;
            end
        end
        else if (pos_reg == POS_CMD)
        begin
            letter_next = char_in;
        end
        else if (count_reg >= CNT_W'(MAX_ARG_CHARS))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            if (pos_reg == POS_ARG1)
                arg1_next = arg1_conv;
            else
                arg2_next = arg2_conv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_CMD;
            count_reg  <= '0;
            letter_reg <= '0;
            arg1_reg   <= '{mag: '0, neg: 1'b0, phase: PH_LEAD};
            arg2_reg   <= '{mag: '0, neg: 1'b0, phase: PH_LEAD};
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            letter_reg <= letter_next;
            arg1_reg   <= arg1_next;
            arg2_reg   <= arg2_next;
            ovf_reg    <= ovf_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ARG_CHARS))
        else $error("argument char count past limit");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_term) |=> (pos_reg == POS_CMD) && !ovf_reg && (letter_reg == 8'd0))
        else $error("parse state not cleared after terminator");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(step && is_term)) |=> ovf_reg)
        else $error("overflow flag dropped inside a command");

endmodule

// ----- sv/serial_command_parser_top.sv -----
// ----------------------------------------------------------------------------
// serial_command_parser_top
// Byte-stream text command parser with input register and result register.
// ----------------------------------------------------------------------------
// path: a terminator item passes the input register, then its result is loaded
//   into the result register
// throughput: one item per cycle; a terminator waits only while the result
//   register still holds an item that has not been taken
// reset: terminator 39, delimiter 32, all parse state cleared, both stages empty
// ----------------------------------------------------------------------------
module serial_command_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    scp_byte_if.sink     byte_in,
    scp_result_if.source result_out
);
    import scp_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       is_term;
    logic       advance;

    scp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (advance),
        .char_in (byte_reg),
        .is_term (is_term),
        .result  (result)
    );

    // a terminator needs a free result slot, other bytes always move on
    assign advance       = in_valid_reg && (!is_term || !out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_in.ready)
            in_valid_reg <= byte_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
            byte_reg <= byte_in.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && is_term)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_term)
            out_reg <= result;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.command_letter = out_reg.command_letter;
    assign result_out.first_value    = out_reg.first_value;
    assign result_out.second_value   = out_reg.second_value;
    assign result_out.fields_seen    = out_reg.fields_seen;
    assign result_out.too_long       = out_reg.too_long;

    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && is_term))
        else $error("result appeared without a terminator");

    a_term_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_term) |=> out_valid_reg)
        else $error("terminator did not load result register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(byte_reg))
        else $error("held input item lost or changed");

endmodule
